// ===== rtl/relativistic_boris_push_macros.svh =====
// assertion macros used by the checker file
`ifndef RELATIVISTIC_BORIS_PUSH_MACROS_SVH
`define RELATIVISTIC_BORIS_PUSH_MACROS_SVH

// check under reset disable
`define BRP_ASSERT(lbl, ck, rstn, prop) lbl: assert property (@(posedge ck) \
	disable iff (!rstn) prop) else $error("brp assertion failed");

// check that also holds while reset is applied
`define BRP_ASSERT_NR(lbl, ck, prop) lbl: assert property (@(posedge ck) prop) \
	else $error("brp assertion failed");

`endif

// ===== rtl/brp_pkg.sv =====
`default_nettype none
package brp_pkg;
	localparam int QW = 32;
	localparam int FRAC = 16;
	localparam int SQRT_LAT = QW;
	localparam int DIV_LAT = QW;
	localparam int PIPE_LAT = 5 + SQRT_LAT + 2 + DIV_LAT + 2 + DIV_LAT + 6 + 2 + SQRT_LAT
		+ DIV_LAT + 1;
	localparam int CFG_AW = 2;

	typedef logic signed [QW-1:0] q_t;
	typedef logic signed [2*QW-1:0] prod_t;
	typedef logic [CFG_AW-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_TIME_STEP = CFG_AW'(0);
	localparam cfg_idx_t REG_CHARGE = CFG_AW'(1);
	localparam cfg_idx_t REG_MASS = CFG_AW'(2);

	localparam q_t QMAX = 32'sh7FFF_FFFF;
	localparam q_t QMIN = 32'sh8000_0000;
	localparam q_t ONE_Q = 32'sd65536;
	localparam prod_t SAT_HI = 64'sd2147483647;
	localparam prod_t SAT_LO = -64'sd2147483648;

	function automatic q_t sat32(input prod_t v);
		if (v > SAT_HI) begin
			return QMAX;
		end else if (v < SAT_LO) begin
			return QMIN;
		end
		return v[QW-1:0];
	endfunction

	// product back to q16.16, floor rounding, clamped
	function automatic q_t qround(input prod_t p);
		return sat32(p >>> FRAC);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/brp_delay.sv =====
`default_nettype none
module brp_delay #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld_in,
	input  logic [W-1:0] din,
	output logic         vld_out,
	output logic [W-1:0] dout
);
	// D is at least 2
	logic [D-1:0] vld_q;
	logic [W-1:0] dat_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[D-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		dat_q[0] <= din;
		for (int k = 1; k < D; k++) begin
			dat_q[k] <= dat_q[k-1];
		end
	end

	assign vld_out = vld_q[D-1];
	assign dout = dat_q[D-1];
endmodule
`default_nettype wire

// ===== rtl/brp_sqrt.sv =====
`default_nettype none
module brp_sqrt import brp_pkg::*; (
	input  logic            clk,
	input  logic [2*QW-1:0] x,
	output logic [QW-1:0]   root
);
	// one result bit per stage
	localparam int RW = QW + 3;

	logic [RW-1:0]   rem_s  [SQRT_LAT];
	logic [QW-1:0]   root_s [SQRT_LAT];
	logic [2*QW-1:0] xs_s   [SQRT_LAT];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		logic [RW-1:0]   rem_in, rem_sh, trial;
		logic [QW-1:0]   root_in;
		logic [2*QW-1:0] xs_in;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign xs_in = x;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign xs_in = xs_s[k-1];
		end

		always_comb begin
			rem_sh = {rem_in[RW-3:0], xs_in[2*QW-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			ge = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? rem_sh - trial : rem_sh;
			root_s[k] <= {root_in[QW-2:0], ge};
			xs_s[k] <= {xs_in[2*QW-3:0], 2'b00};
		end
	end

	assign root = root_s[SQRT_LAT-1];
endmodule
`default_nettype wire

// ===== rtl/brp_div.sv =====
`default_nettype none
module brp_div import brp_pkg::*; #(
	parameter int NW = 63,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          neg,
	input  logic [NW-1:0] num_mag,
	input  logic [DW-1:0] den,
	output q_t            quo
);
	// range check first, then one quotient bit per stage
	localparam int QB = QW - 1;
	localparam int RW = (NW > DW + QB) ? NW : DW + QB;

	logic [RW-1:0] rem_s  [DIV_LAT];
	logic [RW-1:0] den_s  [DIV_LAT];
	logic [QB-1:0] quo_s  [DIV_LAT];
	logic          neg_s  [DIV_LAT];
	logic          ovf_s  [DIV_LAT];
	logic          zero_s [DIV_LAT];
	logic [QW-1:0] q_mag;

	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(num_mag);
		den_s[0] <= RW'(den);
		quo_s[0] <= '0;
		neg_s[0] <= neg;
		ovf_s[0] <= RW'(num_mag) >= (RW'(den) << QB);
		zero_s[0] <= den == '0;
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = den_s[k-1] << (QB - k);
			ge = rem_s[k-1] >= trial;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? rem_s[k-1] - trial : rem_s[k-1];
			den_s[k] <= den_s[k-1];
			quo_s[k] <= {quo_s[k-1][QB-2:0], ge};
			neg_s[k] <= neg_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
			zero_s[k] <= zero_s[k-1];
		end
	end

	always_comb begin
		q_mag = {1'b0, quo_s[DIV_LAT-1]};
		if (zero_s[DIV_LAT-1]) begin
			quo = '0;
		end else if (ovf_s[DIV_LAT-1]) begin
			quo = neg_s[DIV_LAT-1] ? QMIN : QMAX;
		end else begin
			quo = neg_s[DIV_LAT-1] ? -q_t'(q_mag) : q_t'(q_mag);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/relativistic_boris_push.sv =====
// relativistic boris particle push, signed q16.16, saturating
// input channel: drive the particle fields and pulse start; a beat is taken on
//   every clock edge with start high and busy low. busy is always low, so a
//   new particle can enter on every cycle
// output channel: done is high for one cycle with the new momentum and
//   position; the receiver cannot stall and the block never holds results back
// config: cfg_we with cfg_index (0 time step, 1 charge, 2 mass) and
//   cfg_wdata, taken on the edge; write only while no beat is in flight.
//   the derived charge factor and mass square follow in the next cycle
// path: an accepted beat reaches done through two 32-stage square roots
//   and three 32-stage dividers in series
//   (energy, rotation vector h, vector s, second energy, position step)
// throughput: one particle per cycle
// reset: arst_n clears all valid bits and restores the register defaults;
//   beats in flight are dropped
`default_nettype none
module relativistic_boris_push import brp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  logic [31:0] cfg_wdata,
	input  q_t       mom_x,
	input  q_t       mom_y,
	input  q_t       mom_z,
	input  q_t       pos_x,
	input  q_t       pos_y,
	input  q_t       e_x,
	input  q_t       e_y,
	input  q_t       e_z,
	input  q_t       b_x,
	input  q_t       b_y,
	input  q_t       b_z,
	output logic     done,
	output q_t       new_mom_x,
	output q_t       new_mom_y,
	output q_t       new_mom_z,
	output q_t       new_pos_x,
	output q_t       new_pos_y
);
	// configuration and derived constants
	logic [30:0] time_step_q;
	q_t          charge_q;
	logic [30:0] mass_q;
	q_t          q0_q;      // dt*q/2
	logic [61:0] msq_q;     // m*m, q32.32
	prod_t       dtq;

	// front: half-step momentum and energy square
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	q_t    p_s1 [3], e_s1 [3], b_s1 [3], r_s1 [2];
	prod_t pe_s2 [3];
	q_t    p_s2 [3], b_s2 [3], r_s2 [2];
	q_t    eq_s3 [3], w_s3 [3], b_s3 [3], r_s3 [2];
	logic [63:0] sq_s4 [3];
	q_t    eq_s4 [3], w_s4 [3], b_s4 [3], r_s4 [2];
	logic [63:0] acc_s5;
	q_t    eq_s5 [3], w_s5 [3], b_s5 [3], r_s5 [2];

	// after first square root
	logic [QW-1:0] g_s37;
	logic          vld_s37;
	logic [351:0]  dly_a;
	q_t    eq_s37 [3], w_s37 [3], b_s37 [3], r_s37 [2];
	logic  vld_s38, vld_s39;
	prod_t bq_s38 [3];
	logic [QW-1:0] g_s38, g_s39;
	q_t    eq_s38 [3], w_s38 [3], r_s38 [2];
	logic  bqneg_s39 [3];
	logic [62:0] bqmag_s39 [3];
	logic [62:0] bqabs [3];
	q_t    eq_s39 [3], w_s39 [3], r_s39 [2];

	// after h division
	q_t    h_s71 [3];
	logic  vld_s71;
	logic [255:0] dly_b;
	q_t    eq_s71 [3], w_s71 [3], r_s71 [2];
	logic  vld_s72, vld_s73;
	logic [63:0] hsq_s72 [3];
	q_t    h_s72 [3], eq_s72 [3], w_s72 [3], r_s72 [2];
	logic [63:0] hsum;
	logic [31:0] habs [3];
	logic [48:0] den_s73;
	logic  snneg_s73 [3];
	logic [48:0] snmag_s73 [3];
	q_t    h_s73 [3], eq_s73 [3], w_s73 [3], r_s73 [2];

	// after s division: rotation
	q_t    s_s105 [3];
	logic  vld_s105;
	logic [351:0] dly_c;
	q_t    h_s105 [3], eq_s105 [3], w_s105 [3], r_s105 [2];
	logic  vld_s106, vld_s107, vld_s108, vld_s109, vld_s110, vld_s111;
	prod_t phs_s106 [3], psw_s106 [3], pxa_s106 [3], pxb_s106 [3];
	q_t    h_s106 [3], eq_s106 [3], w_s106 [3], r_s106 [2];
	q_t    qhs_s107 [3], qsw_s107 [3], qxa_s107 [3], qxb_s107 [3];
	q_t    h_s107 [3], eq_s107 [3], w_s107 [3], r_s107 [2];
	q_t    hs;
	q_t    omh_s108, sw_s108;
	q_t    cr_s108 [3], h_s108 [3], eq_s108 [3], w_s108 [3], r_s108 [2];
	prod_t pwo_s109 [3], phw_s109 [3];
	q_t    cr_s109 [3], eq_s109 [3], r_s109 [2];
	q_t    qwo_s110 [3], qhw_s110 [3], cr_s110 [3], eq_s110 [3], r_s110 [2];
	q_t    np_s111 [3], r_s111 [2];

	// second energy and position step
	logic  vld_s112, vld_s113;
	logic [63:0] npsq_s112 [3];
	prod_t pdt_s112 [2];
	q_t    np_s112 [3], r_s112 [2];
	logic [63:0] acc_s113;
	logic  pdneg_s113 [2];
	logic [62:0] pdmag_s113 [2];
	logic [62:0] pdabs [2];
	q_t    np_s113 [3], r_s113 [2];
	logic [QW-1:0] g_s145;
	logic  vld_s145;
	logic [287:0] dly_d;
	logic  pdneg_s145 [2];
	logic [62:0] pdmag_s145 [2];
	q_t    np_s145 [3], r_s145 [2];
	q_t    step_s177 [2];
	logic  vld_s177;
	logic [159:0] dly_e;
	q_t    np_s177 [3], r_s177 [2];

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 31'd3277;
			charge_q <= -32'sd65536;
			mass_q <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_wdata[30:0];
				REG_CHARGE:    charge_q <= cfg_wdata;
				REG_MASS:      mass_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign dtq = $signed({1'b0, time_step_q}) * charge_q;

	// derived constants follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q <= -32'sd1639;
			msq_q <= 62'd4294967296;
		end else begin
			q0_q <= sat32(dtq >>> (FRAC + 1));
			msq_q <= mass_q * mass_q;
		end
	end

	// valid bits of the explicit stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s72 <= 1'b0;
			vld_s73 <= 1'b0;
			vld_s106 <= 1'b0;
			vld_s107 <= 1'b0;
			vld_s108 <= 1'b0;
			vld_s109 <= 1'b0;
			vld_s110 <= 1'b0;
			vld_s111 <= 1'b0;
			vld_s112 <= 1'b0;
			vld_s113 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s38 <= vld_s37;
			vld_s39 <= vld_s38;
			vld_s72 <= vld_s71;
			vld_s73 <= vld_s72;
			vld_s106 <= vld_s105;
			vld_s107 <= vld_s106;
			vld_s108 <= vld_s107;
			vld_s109 <= vld_s108;
			vld_s110 <= vld_s109;
			vld_s111 <= vld_s110;
			vld_s112 <= vld_s111;
			vld_s113 <= vld_s112;
			done <= vld_s177;
		end
	end

	// s1: capture the beat
	always_ff @(posedge clk) begin
		p_s1[0] <= mom_x;
		p_s1[1] <= mom_y;
		p_s1[2] <= mom_z;
		e_s1[0] <= e_x;
		e_s1[1] <= e_y;
		e_s1[2] <= e_z;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		r_s1[0] <= pos_x;
		r_s1[1] <= pos_y;
	end

	// s2..s5: q0*e, half-step momentum w, squares, energy square
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pe_s2[i] <= e_s1[i] * q0_q;
			p_s2[i] <= p_s1[i];
			b_s2[i] <= b_s1[i];

			eq_s3[i] <= qround(pe_s2[i]);
			w_s3[i] <= sat32(prod_t'(p_s2[i]) + prod_t'(qround(pe_s2[i])));
			b_s3[i] <= b_s2[i];

			sq_s4[i] <= w_s3[i] * w_s3[i];
			eq_s4[i] <= eq_s3[i];
			w_s4[i] <= w_s3[i];
			b_s4[i] <= b_s3[i];

			eq_s5[i] <= eq_s4[i];
			w_s5[i] <= w_s4[i];
			b_s5[i] <= b_s4[i];
		end
		for (int i = 0; i < 2; i++) begin
			r_s2[i] <= r_s1[i];
			r_s3[i] <= r_s2[i];
			r_s4[i] <= r_s3[i];
			r_s5[i] <= r_s4[i];
		end
		// cannot wrap: m*m and three squares stay below 2^64
		acc_s5 <= 64'(msq_q) + sq_s4[0] + sq_s4[1] + sq_s4[2];
	end

	// lorentz energy of w
	brp_sqrt u_sqrt_g (
		.clk  (clk),
		.x    (acc_s5),
		.root (g_s37)
	);

	brp_delay #(.W(352), .D(SQRT_LAT)) u_dly_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s5),
		.din     ({w_s5[0], w_s5[1], w_s5[2], eq_s5[0], eq_s5[1], eq_s5[2],
			b_s5[0], b_s5[1], b_s5[2], r_s5[0], r_s5[1]}),
		.vld_out (vld_s37),
		.dout    (dly_a)
	);

	assign {w_s37[0], w_s37[1], w_s37[2], eq_s37[0], eq_s37[1], eq_s37[2],
		b_s37[0], b_s37[1], b_s37[2], r_s37[0], r_s37[1]} = dly_a;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bqabs[i] = bq_s38[i][63] ? 63'(-bq_s38[i]) : 63'(bq_s38[i]);
		end
	end

	// s38, s39: b*q0 exact, then sign and magnitude for the divider
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			bq_s38[i] <= b_s37[i] * q0_q;
			eq_s38[i] <= eq_s37[i];
			w_s38[i] <= w_s37[i];
			bqneg_s39[i] <= bq_s38[i][63];
			bqmag_s39[i] <= bqabs[i];
			eq_s39[i] <= eq_s38[i];
			w_s39[i] <= w_s38[i];
		end
		for (int i = 0; i < 2; i++) begin
			r_s38[i] <= r_s37[i];
			r_s39[i] <= r_s38[i];
		end
		g_s38 <= g_s37;
		g_s39 <= g_s38;
	end

	// h = q0*b / g
	for (genvar i = 0; i < 3; i++) begin : g_hdiv
		brp_div #(.NW(63), .DW(QW)) u_div_h (
			.clk     (clk),
			.neg     (bqneg_s39[i]),
			.num_mag (bqmag_s39[i]),
			.den     (g_s39),
			.quo     (h_s71[i])
		);
	end

	brp_delay #(.W(256), .D(DIV_LAT)) u_dly_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s39),
		.din     ({w_s39[0], w_s39[1], w_s39[2], eq_s39[0], eq_s39[1], eq_s39[2],
			r_s39[0], r_s39[1]}),
		.vld_out (vld_s71),
		.dout    (dly_b)
	);

	assign {w_s71[0], w_s71[1], w_s71[2], eq_s71[0], eq_s71[1], eq_s71[2],
		r_s71[0], r_s71[1]} = dly_b;

	always_comb begin
		// three squares of 32-bit values never wrap 64 bits
		hsum = hsq_s72[0] + hsq_s72[1] + hsq_s72[2];
		for (int i = 0; i < 3; i++) begin
			habs[i] = h_s72[i][QW-1] ? 32'(-h_s72[i]) : 32'(h_s72[i]);
		end
	end

	// s72, s73: h.h, divisor 1 + h.h and numerators 2h
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hsq_s72[i] <= h_s71[i] * h_s71[i];
			h_s72[i] <= h_s71[i];
			eq_s72[i] <= eq_s71[i];
			w_s72[i] <= w_s71[i];
			snneg_s73[i] <= h_s72[i][QW-1];
			snmag_s73[i] <= {habs[i], 17'd0};
			h_s73[i] <= h_s72[i];
			eq_s73[i] <= eq_s72[i];
			w_s73[i] <= w_s72[i];
		end
		for (int i = 0; i < 2; i++) begin
			r_s72[i] <= r_s71[i];
			r_s73[i] <= r_s72[i];
		end
		den_s73 <= 49'(ONE_Q) + 49'(hsum >> FRAC);
	end

	// s = 2h / (1 + h.h)
	for (genvar i = 0; i < 3; i++) begin : g_sdiv
		brp_div #(.NW(49), .DW(49)) u_div_s (
			.clk     (clk),
			.neg     (snneg_s73[i]),
			.num_mag (snmag_s73[i]),
			.den     (den_s73),
			.quo     (s_s105[i])
		);
	end

	brp_delay #(.W(352), .D(DIV_LAT)) u_dly_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s73),
		.din     ({h_s73[0], h_s73[1], h_s73[2], w_s73[0], w_s73[1], w_s73[2],
			eq_s73[0], eq_s73[1], eq_s73[2], r_s73[0], r_s73[1]}),
		.vld_out (vld_s105),
		.dout    (dly_c)
	);

	assign {h_s105[0], h_s105[1], h_s105[2], w_s105[0], w_s105[1], w_s105[2],
		eq_s105[0], eq_s105[1], eq_s105[2], r_s105[0], r_s105[1]} = dly_c;

	assign hs = sat32(prod_t'(qhs_s107[0]) + prod_t'(qhs_s107[1]) + prod_t'(qhs_s107[2]));

	// s106..s111: rotation, p' = q0*e + w(1 - h.s) + w x s + h(s.w)
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			phs_s106[i] <= h_s105[i] * s_s105[i];
			psw_s106[i] <= s_s105[i] * w_s105[i];
			h_s106[i] <= h_s105[i];
			eq_s106[i] <= eq_s105[i];
			w_s106[i] <= w_s105[i];

			qhs_s107[i] <= qround(phs_s106[i]);
			qsw_s107[i] <= qround(psw_s106[i]);
			qxa_s107[i] <= qround(pxa_s106[i]);
			qxb_s107[i] <= qround(pxb_s106[i]);
			h_s107[i] <= h_s106[i];
			eq_s107[i] <= eq_s106[i];
			w_s107[i] <= w_s106[i];

			cr_s108[i] <= sat32(prod_t'(qxa_s107[i]) - prod_t'(qxb_s107[i]));
			h_s108[i] <= h_s107[i];
			eq_s108[i] <= eq_s107[i];
			w_s108[i] <= w_s107[i];

			pwo_s109[i] <= w_s108[i] * omh_s108;
			phw_s109[i] <= h_s108[i] * sw_s108;
			cr_s109[i] <= cr_s108[i];
			eq_s109[i] <= eq_s108[i];

			qwo_s110[i] <= qround(pwo_s109[i]);
			qhw_s110[i] <= qround(phw_s109[i]);
			cr_s110[i] <= cr_s109[i];
			eq_s110[i] <= eq_s109[i];

			np_s111[i] <= sat32(prod_t'(eq_s110[i]) + prod_t'(qwo_s110[i])
				+ prod_t'(cr_s110[i]) + prod_t'(qhw_s110[i]));
		end
		// cross product terms w x s
		pxa_s106[0] <= w_s105[1] * s_s105[2];
		pxb_s106[0] <= w_s105[2] * s_s105[1];
		pxa_s106[1] <= w_s105[2] * s_s105[0];
		pxb_s106[1] <= w_s105[0] * s_s105[2];
		pxa_s106[2] <= w_s105[0] * s_s105[1];
		pxb_s106[2] <= w_s105[1] * s_s105[0];

		omh_s108 <= sat32(prod_t'(ONE_Q) - prod_t'(hs));
		sw_s108 <= sat32(prod_t'(qsw_s107[0]) + prod_t'(qsw_s107[1])
			+ prod_t'(qsw_s107[2]));

		for (int i = 0; i < 2; i++) begin
			r_s106[i] <= r_s105[i];
			r_s107[i] <= r_s106[i];
			r_s108[i] <= r_s107[i];
			r_s109[i] <= r_s108[i];
			r_s110[i] <= r_s109[i];
			r_s111[i] <= r_s110[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			pdabs[i] = pdt_s112[i][63] ? 63'(-pdt_s112[i]) : 63'(pdt_s112[i]);
		end
	end

	// s112, s113: energy square of p' and p'*dt
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			npsq_s112[i] <= np_s111[i] * np_s111[i];
			np_s112[i] <= np_s111[i];
			np_s113[i] <= np_s112[i];
		end
		for (int i = 0; i < 2; i++) begin
			pdt_s112[i] <= np_s111[i] * $signed({1'b0, time_step_q});
			r_s112[i] <= r_s111[i];
			pdneg_s113[i] <= pdt_s112[i][63];
			pdmag_s113[i] <= pdabs[i];
			r_s113[i] <= r_s112[i];
		end
		acc_s113 <= 64'(msq_q) + npsq_s112[0] + npsq_s112[1] + npsq_s112[2];
	end

	// energy of the new momentum
	brp_sqrt u_sqrt_g2 (
		.clk  (clk),
		.x    (acc_s113),
		.root (g_s145)
	);

	brp_delay #(.W(288), .D(SQRT_LAT)) u_dly_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s113),
		.din     ({np_s113[0], np_s113[1], np_s113[2], r_s113[0], r_s113[1],
			pdneg_s113[0], pdneg_s113[1], pdmag_s113[0], pdmag_s113[1]}),
		.vld_out (vld_s145),
		.dout    (dly_d)
	);

	assign {np_s145[0], np_s145[1], np_s145[2], r_s145[0], r_s145[1],
		pdneg_s145[0], pdneg_s145[1], pdmag_s145[0], pdmag_s145[1]} = dly_d;

	// position step p'*dt / g'
	for (genvar i = 0; i < 2; i++) begin : g_pdiv
		brp_div #(.NW(63), .DW(QW)) u_div_p (
			.clk     (clk),
			.neg     (pdneg_s145[i]),
			.num_mag (pdmag_s145[i]),
			.den     (g_s145),
			.quo     (step_s177[i])
		);
	end

	brp_delay #(.W(160), .D(DIV_LAT)) u_dly_e (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s145),
		.din     ({np_s145[0], np_s145[1], np_s145[2], r_s145[0], r_s145[1]}),
		.vld_out (vld_s177),
		.dout    (dly_e)
	);

	assign {np_s177[0], np_s177[1], np_s177[2], r_s177[0], r_s177[1]} = dly_e;

	// result register, shown for one cycle with done
	always_ff @(posedge clk) begin
		new_mom_x <= np_s177[0];
		new_mom_y <= np_s177[1];
		new_mom_z <= np_s177[2];
		new_pos_x <= sat32(prod_t'(r_s177[0]) + prod_t'(step_s177[0]));
		new_pos_y <= sat32(prod_t'(r_s177[1]) + prod_t'(step_s177[1]));
	end
endmodule
`default_nettype wire

// ===== rtl/brp_checker.sv =====
`default_nettype none
`include "relativistic_boris_push_macros.svh"
module brp_checker import brp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	// no result beat on the cycle after reset is seen low
	`BRP_ASSERT_NR(a_quiet_in_reset, clk, !arst_n |=> !done)
	// the pusher takes a beat on every cycle
	`BRP_ASSERT(a_never_busy, clk, arst_n, !busy)
	// every result traces back to a beat taken a fixed latency earlier
	`BRP_ASSERT(a_result_latency, clk, arst_n, done |-> $past(start && !busy, PIPE_LAT))
endmodule

bind relativistic_boris_push brp_checker u_brp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
`default_nettype wire
